FILE: design/ssg_pkg.sv
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types, constants and the gap table for the Shell sort block.
// ----------------------------------------------------------------------------
package ssg_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int KEY_WIDTH    = 32;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

  // gaps of the merged sequence that can be below a full store
  localparam int GAP_COUNT    = 4;
  localparam int GAP_POS_W    = $clog2(GAP_COUNT + 1);

  // configuration port
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_DESCENDING = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNED     = 1'b1;

  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [GAP_POS_W-1:0] gap_pos_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // store an incoming word
    logic sort_init;  // pick the number of gaps below the count
    logic gap_step;   // move to the next smaller gap
    logic rd_outer;   // read the element at the outer index
    logic take_held;  // capture the element being inserted
    logic rd_probe;   // read the element one gap below inner
    logic move;       // shift the probed element up by one gap
    logic place;      // drop the held element at inner, advance outer
    logic emit_init;  // rewind the output index
    logic emit;       // read one sorted element out
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic gap_left;
    logic outer_left;
    logic inner_ge_gap;
    logic goes_first;
    logic emit_last;
  } sts_t;

  // gap table, smallest first
  function automatic count_t gap_of(input gap_pos_t pos);
    count_t g;
    case (pos)
      3'd0:    g = CNT_W'(1);
      3'd1:    g = CNT_W'(5);
      3'd2:    g = CNT_W'(19);
      3'd3:    g = CNT_W'(41);
      default: g = CNT_W'(1);
    endcase
    return g;
  endfunction

endpackage

FILE: design/ssg_ram.sv
// ----------------------------------------------------------------------------
// ssg_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/ssg_datapath.sv
// ----------------------------------------------------------------------------
// ssg_datapath
// Element store, indexes, held key, comparator and output registers.
// ----------------------------------------------------------------------------
module ssg_datapath
  import ssg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  key_t                   key_value,
  output logic                   result_strobe,
  output key_t                   sorted_value,
  output logic                   last_out,
  output logic                   overflowed
);

  logic     descending_order;
  logic     signed_keys;
  count_t   element_count;
  logic     overflow_flag;
  gap_pos_t gap_position;
  count_t   gap;
  count_t   outer_index;
  count_t   inner_index;
  key_t     held_key;
  addr_t    emit_index;
  logic     strobe;
  logic     last_reg;
  logic     ovf_reg;

  logic     store_we;
  addr_t    store_waddr;
  key_t     store_wdata;
  addr_t    store_raddr;
  key_t     store_rdata;
  logic     has_room;
  count_t   inner_minus_gap;
  gap_pos_t used_gaps;
  key_t     sign_mask;
  key_t     held_cmp;
  key_t     probe_cmp;

  assign has_room        = element_count < CNT_W'(MAX_ELEMENTS);
  assign inner_minus_gap = inner_index - gap;

  // number of gaps strictly below the element count
  always_comb begin
    used_gaps = '0;
    for (int k = 0; k < GAP_COUNT; k++) begin
      if (gap_of(GAP_POS_W'(k)) < element_count) begin
        used_gaps = used_gaps + GAP_POS_W'(1);
      end
    end
  end

  // comparator: flip sign bits for two's complement keys
  assign sign_mask = {signed_keys, {(KEY_WIDTH-1){1'b0}}};
  assign held_cmp  = held_key ^ sign_mask;
  assign probe_cmp = store_rdata ^ sign_mask;

  // status back to the controller
  always_comb begin
    sts.gap_left     = gap_position != '0;
    sts.outer_left   = outer_index < element_count;
    sts.inner_ge_gap = inner_index >= gap;
    sts.goes_first   = descending_order ? (held_cmp > probe_cmp) : (held_cmp < probe_cmp);
    sts.emit_last    = (CNT_W'(emit_index) + CNT_W'(1)) == element_count;
  end

  // store port selection
  always_comb begin
    store_we    = (cmd.load && has_room) || cmd.move || cmd.place;
    store_waddr = cmd.load ? element_count[ADDR_W-1:0] : inner_index[ADDR_W-1:0];
    if (cmd.load) begin
      store_wdata = key_value;
    end else if (cmd.move) begin
      store_wdata = store_rdata;
    end else begin
      store_wdata = held_key;
    end
    if (cmd.rd_outer) begin
      store_raddr = outer_index[ADDR_W-1:0];
    end else if (cmd.rd_probe) begin
      store_raddr = inner_minus_gap[ADDR_W-1:0];
    end else begin
      store_raddr = emit_index;
    end
  end

  ssg_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      descending_order <= 1'b0;
      signed_keys      <= 1'b0;
      element_count    <= '0;
      overflow_flag    <= 1'b0;
      gap_position     <= '0;
      strobe           <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DESCENDING: descending_order <= cfg_data[0];
          REG_SIGNED:     signed_keys      <= cfg_data[0];
          default:        ;
        endcase
      end
      if (cmd.load) begin
        if (has_room) begin
          element_count <= element_count + CNT_W'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
      end
      if (cmd.sort_init) begin
        gap_position <= used_gaps;
      end else if (cmd.gap_step) begin
        gap_position <= gap_position - GAP_POS_W'(1);
      end
      if (cmd.emit && sts.emit_last) begin
        element_count <= '0;
        overflow_flag <= 1'b0;
      end
      strobe <= cmd.emit;
    end
  end

  // index and key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gap         <= CNT_W'(1);
      outer_index <= '0;
      inner_index <= '0;
      held_key    <= '0;
      emit_index  <= '0;
      last_reg    <= 1'b0;
      ovf_reg     <= 1'b0;
    end else begin
      if (cmd.gap_step) begin
        gap         <= gap_of(gap_position - GAP_POS_W'(1));
        outer_index <= gap_of(gap_position - GAP_POS_W'(1));
      end
      if (cmd.rd_outer) begin
        inner_index <= outer_index;
      end
      if (cmd.take_held) begin
        held_key <= store_rdata;
      end
      if (cmd.move) begin
        inner_index <= inner_minus_gap;
      end
      if (cmd.place) begin
        outer_index <= outer_index + CNT_W'(1);
      end
      if (cmd.emit_init) begin
        emit_index <= '0;
      end else if (cmd.emit) begin
        emit_index <= emit_index + ADDR_W'(1);
        last_reg   <= sts.emit_last;
        ovf_reg    <= overflow_flag;
      end
    end
  end

  // result ports, data straight from the registered store read
  assign result_strobe = strobe;
  assign sorted_value  = store_rdata;
  assign last_out      = strobe & last_reg;
  assign overflowed    = strobe & ovf_reg;

endmodule

FILE: design/ssg_ctrl.sv
// ----------------------------------------------------------------------------
// ssg_ctrl
// Controller state machine: load, gapped insertion passes, read-out.
// ----------------------------------------------------------------------------
module ssg_ctrl
  import ssg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic last_in,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_GAP   = 3'd2;
  localparam logic [2:0] S_RDH   = 3'd3;
  localparam logic [2:0] S_HOLD  = 3'd4;
  localparam logic [2:0] S_PROBE = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_in) begin
            state_next = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.sort_init = 1'b1;
        state_next    = S_GAP;
      end
      S_GAP: begin
        if (sts.gap_left) begin
          cmd.gap_step = 1'b1;
          state_next   = S_RDH;
        end else begin
          cmd.emit_init = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_RDH: begin
        if (sts.outer_left) begin
          cmd.rd_outer = 1'b1;
          state_next   = S_HOLD;
        end else begin
          state_next = S_GAP;
        end
      end
      S_HOLD: begin
        cmd.take_held = 1'b1;
        state_next    = S_PROBE;
      end
      S_PROBE: begin
        if (sts.inner_ge_gap) begin
          cmd.rd_probe = 1'b1;
          state_next   = S_CMP;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_RDH;
        end
      end
      S_CMP: begin
        if (sts.goes_first) begin
          cmd.move   = 1'b1;
          state_next = S_PROBE;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_RDH;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;

endmodule

FILE: design/shell_sort_sedgewick_gaps.sv
// Loading takes one word per cycle while idle; a set starts sorting on the word marked last.
// Sorting runs one gapped insertion pass per gap, largest gap first, moving each key down
// one gap per compare; the single store read port sets the pace.
// Results follow back to back, the first in the cycle after the read-out begins.
// Reset is synchronous: it clears counts, flags and configuration, not the store.
// Results cannot be stalled; a new set loads from the cycle of the final result.
// ----------------------------------------------------------------------------
// shell_sort_sedgewick_gaps
// Shell sort of up to 64 keys with the merged Sedgewick gap sequence.
// ----------------------------------------------------------------------------
module shell_sort_sedgewick_gaps
  import ssg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [31:0]            key_value,
  input  logic                   last_in,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   result_strobe,
  output logic [31:0]            sorted_value,
  output logic                   last_out,
  output logic                   overflowed
);

  cmd_t cmd;
  sts_t sts;

  ssg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .last_in (last_in),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  ssg_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .key_value     (key_value),
    .result_strobe (result_strobe),
    .sorted_value  (sorted_value),
    .last_out      (last_out),
    .overflowed    (overflowed)
  );

endmodule

FILE: design/ssg_checker.sv
// ----------------------------------------------------------------------------
// ssg_checker
// Port-level checks of the sort block, bound to the top level.
// ----------------------------------------------------------------------------
module ssg_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last_in,
  input logic result_strobe,
  input logic last_out
);

  // reset leaves the block idle and quiet
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !result_strobe)
    else $error("block not idle after reset");

  // a word that is not last keeps the block accepting
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !last_in |=> !busy)
    else $error("busy after a non-final word");

  // the final word starts the sort
  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last_in |=> busy)
    else $error("sort did not start on final word");

  // every result comes out of a read-out phase
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result without a sort in progress");

  // the final result closes the set
  a_last_closes_set: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last_out |=> !result_strobe)
    else $error("result after the final one");

endmodule

bind shell_sort_sedgewick_gaps ssg_checker u_checker (.*);
